>>> hw/rtl/fbb_pkg.sv
// Free block bitmap: shared field widths, request and state codes, structs and
// byte helper functions. No dependencies.
package fbb_pkg;

    localparam int TYPE_W     = 3;
    localparam int BIT_IDX_W  = 10;
    localparam int BYTE_IDX_W = 7;
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 11;
    localparam int ADDR_W     = 8;

    localparam logic [7:0] CFG_RESET      = 8'd128;
    localparam logic [7:0] SCAN_MAX_BYTES = 8'd128;

    typedef enum logic [TYPE_W-1:0] {
        REQ_FILL      = 3'd0,
        REQ_WRITE_BIT = 3'd1,
        REQ_FIND      = 3'd2,
        REQ_LOAD      = 3'd3,
        REQ_READ      = 3'd4
    } req_type_e_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_MODIFY,
        ST_SCAN,
        ST_COUNT,
        ST_DONE
    } fbb_state_t;

    typedef struct packed {
        logic [TYPE_W-1:0]     req_type;
        logic                  bit_value;
        logic [BIT_IDX_W-1:0]  bit_index;
        logic [BYTE_IDX_W-1:0] byte_index;
        logic [BYTE_W-1:0]     byte_data;
    } req_t;

    typedef struct packed {
        logic                 status;
        logic                 found;
        logic [BIT_IDX_W-1:0] found_index;
        logic [COUNT_W-1:0]   ones_count;
        logic [BYTE_W-1:0]    read_byte;
    } rsp_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] c;
        c = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            c = c + 4'(v[i]);
        end
        return c;
    endfunction

    // position of the first set bit counted from the MSB
    function automatic logic [2:0] first_one8(input logic [7:0] v);
        logic [2:0] pos;
        logic       hit;
        pos = 3'd0;
        hit = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (v[7-i] && !hit)
            begin
                pos = 3'(i);
                hit = 1'b1;
            end
        end
        return pos;
    endfunction

endpackage

>>> hw/rtl/fbb_if.sv
// Free block bitmap: valid/ready channel interfaces for requests and results.
// Depends on fbb_pkg.
interface fbb_req_if import fbb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [TYPE_W-1:0]     req_type;
    logic                  bit_value;
    logic [BIT_IDX_W-1:0]  bit_index;
    logic [BYTE_IDX_W-1:0] byte_index;
    logic [BYTE_W-1:0]     byte_data;

    modport source (output valid, req_type, bit_value, bit_index, byte_index, byte_data,
                    input ready);
    modport sink   (input valid, req_type, bit_value, bit_index, byte_index, byte_data,
                    output ready);
endinterface

interface fbb_rsp_if import fbb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 status;
    logic                 found;
    logic [BIT_IDX_W-1:0] found_index;
    logic [COUNT_W-1:0]   ones_count;
    logic [BYTE_W-1:0]    read_byte;

    modport source (output valid, status, found, found_index, ones_count, read_byte,
                    input ready);
    modport sink   (input valid, status, found, found_index, ones_count, read_byte,
                    output ready);
endinterface

>>> hw/rtl/fbb_mem.sv
// Free block bitmap: byte memory, one write and one registered read port,
// with per-entry valid flags so unwritten entries read as zero. Depends on fbb_pkg.
module fbb_mem import fbb_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  mem_req_t          mreq,
    output logic [BYTE_W-1:0] rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    logic [BYTE_W-1:0] rdata_reg;
    logic              rvld_reg;

    always_ff @(posedge clk)
    begin
        if (mreq.we)
        begin
            mem[mreq.waddr[AW-1:0]] <= mreq.wdata;
        end
        rdata_reg <= mem[mreq.raddr[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (mreq.we)
            begin
                vld_reg[mreq.waddr[AW-1:0]] <= 1'b1;
            end
            rvld_reg <= vld_reg[mreq.raddr[AW-1:0]];
        end
    end

    assign rd_data = rvld_reg ? rdata_reg : '0;

endmodule

>>> hw/rtl/fbb_ctrl.sv
// Free block bitmap: request sequencer. Read-modify-write, fill sweep,
// find-first scan and recount over the byte memory. Depends on fbb_pkg.
module fbb_ctrl import fbb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        live,
    input  logic              recount,
    input  logic              start,
    input  req_t              req_in,
    output logic              idle_ready,
    output logic              res_valid,
    input  logic              res_take,
    output rsp_t              res,
    output mem_req_t          mreq,
    input  logic [BYTE_W-1:0] rd_data
);
    fbb_state_t           state_reg, state_next;
    req_type_e_t          op_reg, op_next;
    logic                 val_reg, val_next;
    logic [2:0]           bpos_reg, bpos_next;
    logic [BYTE_W-1:0]    data_reg, data_next;
    logic [ADDR_W-1:0]    ptr_reg, ptr_next;
    logic [COUNT_W-1:0]   sum_reg, sum_next;
    logic [COUNT_W-1:0]   ones_reg, ones_next;
    logic                 status_reg, status_next;
    logic                 found_reg, found_next;
    logic [BIT_IDX_W-1:0] fidx_reg, fidx_next;
    logic [BYTE_W-1:0]    rbyte_reg, rbyte_next;

    req_type_e_t        in_op;
    logic [7:0]         lim;
    logic [COUNT_W-1:0] live_bits;
    logic               live_zero;
    logic               bit_err;
    logic               byte_err;
    logic               live_last;
    logic               lim_last;
    logic [BYTE_W-1:0]  match_byte;
    logic               match_hit;
    logic [BYTE_W-1:0]  mask;
    logic [BYTE_W-1:0]  new_byte;
    logic [COUNT_W-1:0] ones_adj;
    logic [COUNT_W-1:0] sum_add;
    logic [ADDR_W-1:0]  in_addr;

    always_comb
    begin
        in_op      = req_type_e_t'(req_in.req_type);
        lim        = (live > SCAN_MAX_BYTES) ? SCAN_MAX_BYTES : live;
        live_bits  = {live, 3'b000};
        live_zero  = (live == 8'd0);
        bit_err    = (COUNT_W'(req_in.bit_index) >= live_bits);
        byte_err   = (8'(req_in.byte_index) >= live);
        live_last  = (ptr_reg == 8'(live - 8'd1));
        lim_last   = (ptr_reg == 8'(lim - 8'd1));
        match_byte = val_reg ? rd_data : ~rd_data;
        match_hit  = (match_byte != 8'd0);
        mask       = 8'h80 >> bpos_reg;
        if (op_reg == REQ_LOAD)
        begin
            new_byte = data_reg;
        end
        else
        begin
            new_byte = val_reg ? (rd_data | mask) : (rd_data & ~mask);
        end
        ones_adj = ones_reg - COUNT_W'(pop8(rd_data)) + COUNT_W'(pop8(new_byte));
        sum_add  = sum_reg + COUNT_W'(pop8(rd_data));
        if (in_op == REQ_WRITE_BIT)
        begin
            in_addr = {1'b0, req_in.bit_index[BIT_IDX_W-1:3]};
        end
        else if (in_op == REQ_LOAD || in_op == REQ_READ)
        begin
            in_addr = {1'b0, req_in.byte_index};
        end
        else
        begin
            in_addr = '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (recount)
                begin
                    state_next = live_zero ? ST_IDLE : ST_COUNT;
                end
                else if (start)
                begin
                    unique case (in_op)
                        REQ_FILL:      state_next = live_zero ? ST_DONE : ST_FILL;
                        REQ_WRITE_BIT: state_next = bit_err ? ST_DONE : ST_MODIFY;
                        REQ_FIND:      state_next = (lim == 8'd0) ? ST_DONE : ST_SCAN;
                        REQ_LOAD,
                        REQ_READ:      state_next = byte_err ? ST_DONE : ST_MODIFY;
                        default:       state_next = ST_DONE;
                    endcase
                end
            end
            ST_FILL:   state_next = live_last ? ST_DONE : ST_FILL;
            ST_MODIFY: state_next = ST_DONE;
            ST_SCAN:   state_next = (match_hit || lim_last) ? ST_DONE : ST_SCAN;
            ST_COUNT:
            begin
                if (recount)
                begin
                    state_next = live_zero ? ST_IDLE : ST_COUNT;
                end
                else
                begin
                    state_next = live_last ? ST_IDLE : ST_COUNT;
                end
            end
            ST_DONE:   state_next = res_take ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath registers
    always_comb
    begin
        op_next     = op_reg;
        val_next    = val_reg;
        bpos_next   = bpos_reg;
        data_next   = data_reg;
        ptr_next    = ptr_reg;
        sum_next    = sum_reg;
        ones_next   = ones_reg;
        status_next = status_reg;
        found_next  = found_reg;
        fidx_next   = fidx_reg;
        rbyte_next  = rbyte_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (recount)
                begin
                    ptr_next = '0;
                    sum_next = '0;
                    if (live_zero)
                    begin
                        ones_next = '0;
                    end
                end
                else if (start)
                begin
                    op_next     = in_op;
                    val_next    = req_in.bit_value;
                    bpos_next   = req_in.bit_index[2:0];
                    data_next   = req_in.byte_data;
                    ptr_next    = in_addr;
                    status_next = 1'b0;
                    found_next  = 1'b0;
                    fidx_next   = '0;
                    rbyte_next  = '0;
                    if ((in_op == REQ_WRITE_BIT && bit_err) ||
                        ((in_op == REQ_LOAD || in_op == REQ_READ) && byte_err))
                    begin
                        status_next = 1'b1;
                    end
                end
            end
            ST_FILL:
            begin
                ptr_next = 8'(ptr_reg + 8'd1);
                if (live_last)
                begin
                    ones_next = val_reg ? live_bits : '0;
                end
            end
            ST_MODIFY:
            begin
                if (op_reg == REQ_READ)
                begin
                    rbyte_next = rd_data;
                end
                else
                begin
                    ones_next = ones_adj;
                end
            end
            ST_SCAN:
            begin
                if (match_hit)
                begin
                    found_next = 1'b1;
                    fidx_next  = {ptr_reg[BYTE_IDX_W-1:0], first_one8(match_byte)};
                end
                else if (!lim_last)
                begin
                    ptr_next = 8'(ptr_reg + 8'd1);
                end
            end
            ST_COUNT:
            begin
                if (recount)
                begin
                    ptr_next = '0;
                    sum_next = '0;
                    if (live_zero)
                    begin
                        ones_next = '0;
                    end
                end
                else if (live_last)
                begin
                    ones_next = sum_add;
                end
                else
                begin
                    sum_next = sum_add;
                    ptr_next = 8'(ptr_reg + 8'd1);
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        idle_ready  = 1'b0;
        res_valid   = 1'b0;
        mreq.we     = 1'b0;
        mreq.waddr  = ptr_reg;
        mreq.wdata  = new_byte;
        mreq.raddr  = ptr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                idle_ready = !recount;
                mreq.raddr = recount ? '0 : in_addr;
            end
            ST_FILL:
            begin
                mreq.we    = 1'b1;
                mreq.wdata = val_reg ? 8'hFF : 8'h00;
            end
            ST_MODIFY:
            begin
                mreq.we = (op_reg != REQ_READ);
            end
            ST_SCAN:
            begin
                mreq.raddr = lim_last ? ptr_reg : 8'(ptr_reg + 8'd1);
            end
            ST_COUNT:
            begin
                if (recount)
                begin
                    mreq.raddr = '0;
                end
                else
                begin
                    mreq.raddr = live_last ? ptr_reg : 8'(ptr_reg + 8'd1);
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign res.status      = status_reg;
    assign res.found       = found_reg;
    assign res.found_index = fidx_reg;
    assign res.ones_count  = ones_reg;
    assign res.read_byte   = rbyte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ones_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ones_reg  <= ones_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        val_reg    <= val_next;
        bpos_reg   <= bpos_next;
        data_reg   <= data_next;
        ptr_reg    <= ptr_next;
        sum_reg    <= sum_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        fidx_reg   <= fidx_next;
        rbyte_reg  <= rbyte_next;
    end

    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> state_reg != ST_IDLE)
        else $error("request accepted but sequencer stayed idle");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mreq.we |-> mreq.waddr < live)
        else $error("memory write beyond bytes in use");

    a_ones_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && !recount) |-> ones_reg <= live_bits)
        else $error("ones count exceeds live bits");

    a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.found) |-> (COUNT_W'(res.found_index) < {lim, 3'b000}
                                      && !res.status))
        else $error("found index outside search range");

endmodule

>>> hw/rtl/free_block_bitmap_unit.sv
// Free block bitmap top level: configuration register, result register and
// sequencer/memory instances. Depends on fbb_pkg, fbb_if, fbb_mem, fbb_ctrl.
//
// Usage: requests arrive on req (valid/ready), one result per request leaves on
// rsp (valid/ready); a transfer happens when valid and ready are both high.
// cfg_we/cfg_wdata write bytes_in_use (reset 128, limited to MAP_BYTES).
// One request is worked on at a time. Steps from accepted request to the
// result on rsp, paced by the registered memory read and the byte-wide sweep:
//   write bit, load byte, read byte: read, modify/write, done
//   fill: one byte written per cycle over the bytes in use, then done
//   find first: one byte scanned per cycle up to a match or min(bytes in use, 128)
//   out-of-range index, unknown request: straight to done
// ready returns as the result is loaded into the output register, since the
// sequencer goes back to idle on the same edge. After a configuration write, ready
// stays low while the one-bit count is rebuilt from memory.
// Reset clears the count and marks every memory entry as zero through
// per-entry valid flags; no clearing pass is needed.
// A stalled receiver holds the result in the output register; the sequencer
// then waits with its next result and accepts no new request.
module free_block_bitmap_unit import fbb_pkg::*;
#(
    parameter int MAP_BYTES = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    fbb_req_if.sink     req,
    fbb_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    localparam int MEM_DEPTH = (MAP_BYTES < 256) ? MAP_BYTES : 256;

    logic [7:0] cfg_reg;
    logic       recount_reg;
    logic       out_valid_reg;
    rsp_t       out_reg;

    logic [7:0]        live;
    logic              idle_ready;
    logic              start;
    req_t              req_in;
    logic              res_valid;
    logic              res_take;
    rsp_t              res;
    mem_req_t          mreq;
    logic [BYTE_W-1:0] rd_data;

    assign live = (32'(cfg_reg) > MAP_BYTES) ? 8'(MAP_BYTES) : cfg_reg;

    assign req_in.req_type   = req.req_type;
    assign req_in.bit_value  = req.bit_value;
    assign req_in.bit_index  = req.bit_index;
    assign req_in.byte_index = req.byte_index;
    assign req_in.byte_data  = req.byte_data;

    assign req.ready = idle_ready && !cfg_we;
    assign start     = req.valid && req.ready;
    assign res_take  = res_valid && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_RESET;
            recount_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            recount_reg <= cfg_we;
            if (res_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.found       = out_reg.found;
    assign rsp.found_index = out_reg.found_index;
    assign rsp.ones_count  = out_reg.ones_count;
    assign rsp.read_byte   = out_reg.read_byte;

    fbb_mem #(
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .mreq    (mreq),
        .rd_data (rd_data)
    );

    fbb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .live       (live),
        .recount    (recount_reg),
        .start      (start),
        .req_in     (req_in),
        .idle_ready (idle_ready),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res),
        .mreq       (mreq),
        .rd_data    (rd_data)
    );

endmodule

>>> verif/fbb_bitmap_checker.sv
`timescale 1ns / 100ps
// Free block bitmap checker: keeps a shadow bitmap and bytes-in-use register, predicts
// the result of every accepted request and compares it with each result transfer.
// Depends on fbb_pkg and the fbb_req_if / fbb_rsp_if channel interfaces.
module fbb_bitmap_checker import fbb_pkg::*;
#(
    parameter int MAP_BYTES = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    fbb_req_if          req,
    fbb_rsp_if          rsp,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    output int unsigned err_count,
    output int unsigned due_count
);

    localparam int SEARCH_BITS = 1 << BIT_IDX_W;
    localparam int COUNT_SAT   = (1 << COUNT_W) - 1;
    localparam int REPORT_MAX  = 10;

    logic [BYTE_W-1:0] shadow_map [MAP_BYTES];
    logic [7:0]        span_reg;
    rsp_t              rsp_due_q [$];
    int unsigned       failures;
    int unsigned       reports;
    req_t              seen_req;
    rsp_t              seen_rsp;
    rsp_t              want_rsp;
    logic              bad;

    function automatic int unsigned live_span();
        return (int'(span_reg) > MAP_BYTES) ? MAP_BYTES : int'(span_reg);
    endfunction

    function automatic logic [COUNT_W-1:0] tally_ones();
        int unsigned total;
        total = 0;
        for (int i = 0; i < live_span(); i++)
        begin
            total += $countones(shadow_map[i]);
        end
        return (total > COUNT_SAT) ? COUNT_W'(COUNT_SAT) : COUNT_W'(total);
    endfunction

    // applies one request to the shadow map and returns its result
    function automatic rsp_t predict_response(input req_t r);
        rsp_t              o;
        int unsigned       n;
        int unsigned       lim;
        logic [BYTE_W-1:0] mask;
        o = '0;
        n = live_span();
        case (r.req_type)
            REQ_FILL:
            begin
                for (int i = 0; i < n; i++)
                begin
                    shadow_map[i] = r.bit_value ? '1 : '0;
                end
            end
            REQ_WRITE_BIT:
            begin
                if (r.bit_index >= n * BYTE_W)
                begin
                    o.status = 1'b1;
                end
                else
                begin
                    mask = '0;
                    mask[BYTE_W - 1 - (r.bit_index % BYTE_W)] = 1'b1;
                    if (r.bit_value)
                        shadow_map[r.bit_index / BYTE_W] = shadow_map[r.bit_index / BYTE_W] | mask;
                    else
                        shadow_map[r.bit_index / BYTE_W] = shadow_map[r.bit_index / BYTE_W] & ~mask;
                end
            end
            REQ_FIND:
            begin
                lim = n * BYTE_W;
                if (lim > SEARCH_BITS)
                    lim = SEARCH_BITS;
                for (int i = 0; i < lim && !o.found; i++)
                begin
                    if (shadow_map[i / BYTE_W][BYTE_W - 1 - (i % BYTE_W)] == r.bit_value)
                    begin
                        o.found       = 1'b1;
                        o.found_index = BIT_IDX_W'(i);
                    end
                end
            end
            REQ_LOAD:
            begin
                if (r.byte_index >= n)
                    o.status = 1'b1;
                else
                    shadow_map[r.byte_index] = r.byte_data;
            end
            REQ_READ:
            begin
                if (r.byte_index >= n)
                    o.status = 1'b1;
                else
                    o.read_byte = shadow_map[r.byte_index];
            end
            default:
            begin
            end
        endcase
        o.ones_count = tally_ones();
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAP_BYTES; i++)
            begin
                shadow_map[i] = '0;
            end
            span_reg = CFG_RESET;
            rsp_due_q.delete();
            failures = 0;
            reports  = 0;
            err_count <= 0;
            due_count <= 0;
        end
        else
        begin
            if (cfg_we)
                span_reg = cfg_wdata;

            if (req.valid && req.ready)
            begin
                seen_req.req_type   = req.req_type;
                seen_req.bit_value  = req.bit_value;
                seen_req.bit_index  = req.bit_index;
                seen_req.byte_index = req.byte_index;
                seen_req.byte_data  = req.byte_data;
                rsp_due_q.push_back(predict_response(seen_req));
            end

            if (rsp.valid && rsp.ready)
            begin
                seen_rsp.status      = rsp.status;
                seen_rsp.found       = rsp.found;
                seen_rsp.found_index = rsp.found_index;
                seen_rsp.ones_count  = rsp.ones_count;
                seen_rsp.read_byte   = rsp.read_byte;
                if (rsp_due_q.size() == 0)
                begin
                    failures++;
                    if (reports < REPORT_MAX)
                        $display("%0t: result transfer with nothing outstanding", $realtime);
                    reports++;
                end
                else
                begin
                    want_rsp = rsp_due_q.pop_front();
                    bad = (seen_rsp.status      !== want_rsp.status)      ||
                          (seen_rsp.found       !== want_rsp.found)       ||
                          (seen_rsp.found_index !== want_rsp.found_index) ||
                          (seen_rsp.ones_count  !== want_rsp.ones_count)  ||
                          (seen_rsp.read_byte   !== want_rsp.read_byte);
                    if (bad)
                    begin
                        failures++;
                        if (reports < REPORT_MAX)
                        begin
                            $display("%0t: mismatch exp st=%0d fd=%0d idx=%0d ones=%0d byte=%02h",
                                     $realtime, want_rsp.status, want_rsp.found,
                                     want_rsp.found_index, want_rsp.ones_count,
                                     want_rsp.read_byte);
                            $display("%0t:          got st=%0d fd=%0d idx=%0d ones=%0d byte=%02h",
                                     $realtime, seen_rsp.status, seen_rsp.found,
                                     seen_rsp.found_index, seen_rsp.ones_count,
                                     seen_rsp.read_byte);
                        end
                        reports++;
                    end
                end
            end

            err_count <= failures;
            due_count <= rsp_due_q.size();
        end
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Free block bitmap testbench top: clock, reset, bursty request stimulus, result stalls,
// bytes-in-use writes and the final verdict.
// Depends on fbb_pkg, fbb_if, free_block_bitmap_unit and fbb_bitmap_checker.
module tb_top;
    import fbb_pkg::*;

    localparam int MAP_BYTES       = 128;
    localparam int ITEMS_PER_SPAN  = 105;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 2 * MAP_BYTES + 8;
    localparam int IDLE_GUARD      = 4;
    localparam int SPAN_STEPS      = 10;

    localparam logic [TYPE_W-1:0] REQ_CODE_LAST   = '1;
    localparam logic [TYPE_W-1:0] REQ_CODE_UNUSED = TYPE_W'(REQ_READ + 1);
    localparam logic [7:0]        SPAN_MAX        = '1;
    localparam logic [7:0]        SPAN_PLAN [SPAN_STEPS] = '{
        8'd1, 8'd128, 8'd0, SPAN_MAX, 8'd9, 8'd64, 8'd129, 8'd100, 8'd2, 8'd127
    };

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_MOSTLY,
        SINK_CHOKED
    } sink_mode_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    int unsigned err_count;
    int unsigned due_count;
    int unsigned cycles;
    logic        fill_polarity;
    sink_mode_t  sink_mode;
    int unsigned mode_left;

    fbb_req_if req_ch ();
    fbb_rsp_if rsp_ch ();

    free_block_bitmap_unit #(
        .MAP_BYTES (MAP_BYTES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    fbb_bitmap_checker #(
        .MAP_BYTES (MAP_BYTES)
    ) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .err_count (err_count),
        .due_count (due_count)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result back-pressure from one of four randomly chosen patterns
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            sink_mode <= sink_mode_t'($urandom_range(0, 3));
            mode_left <= $urandom_range(20, 300);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        case (sink_mode)
            SINK_OPEN:   rsp_ch.ready <= 1'b1;
            SINK_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
            SINK_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
            default:     rsp_ch.ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    function automatic req_t pack_req(input logic [TYPE_W-1:0] kind, input logic val,
                                      input int unsigned bit_pos, input int unsigned byte_pos,
                                      input int unsigned data);
        req_t r;
        r.req_type   = kind;
        r.bit_value  = val;
        r.bit_index  = BIT_IDX_W'(bit_pos);
        r.byte_index = BYTE_IDX_W'(byte_pos);
        r.byte_data  = BYTE_W'(data);
        return r;
    endfunction

    // mostly well-formed: fills, sparse other-value writes, finds, loads, reads, bad codes
    function automatic req_t random_request(input int unsigned live);
        req_t        r;
        int unsigned pick;
        pick         = $urandom_range(0, 99);
        r.bit_value  = 1'($urandom_range(0, 1));
        r.bit_index  = BIT_IDX_W'($urandom);
        r.byte_index = BYTE_IDX_W'($urandom);
        r.byte_data  = BYTE_W'($urandom);
        if (pick < 6)
        begin
            r.req_type    = REQ_FILL;
            fill_polarity = r.bit_value;
        end
        else if (pick < 36)
        begin
            r.req_type = REQ_WRITE_BIT;
            if ($urandom_range(0, 9) < 7)
                r.bit_value = !fill_polarity;
            if (live != 0 && $urandom_range(0, 6) != 0)
                r.bit_index = BIT_IDX_W'($urandom_range(0, live * BYTE_W - 1));
        end
        else if (pick < 61)
        begin
            r.req_type = REQ_FIND;
            if ($urandom_range(0, 9) < 6)
                r.bit_value = !fill_polarity;
        end
        else if (pick < 74)
        begin
            r.req_type = REQ_LOAD;
            if (live != 0 && $urandom_range(0, 6) != 0)
                r.byte_index = BYTE_IDX_W'($urandom_range(0, live - 1));
            case ($urandom_range(0, 3))
                0:       r.byte_data = '0;
                1:       r.byte_data = '1;
                default: r.byte_data = BYTE_W'($urandom);
            endcase
        end
        else if (pick < 94)
        begin
            r.req_type = REQ_READ;
            if (live != 0 && $urandom_range(0, 6) != 0)
                r.byte_index = BYTE_IDX_W'($urandom_range(0, live - 1));
        end
        else
        begin
            r.req_type = TYPE_W'($urandom_range(int'(REQ_CODE_UNUSED), int'(REQ_CODE_LAST)));
        end
        return r;
    endfunction

    task automatic issue(input req_t r);
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= r.req_type;
        req_ch.bit_value  <= r.bit_value;
        req_ch.bit_index  <= r.bit_index;
        req_ch.byte_index <= r.byte_index;
        req_ch.byte_data  <= r.byte_data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic pause(input int unsigned gap);
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
    endtask

    task automatic set_span(input logic [7:0] span);
        drain();
        repeat (IDLE_GUARD) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= span;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_directed();
        issue(pack_req(REQ_READ,      1'b0, 0,    127, 0));
        issue(pack_req(REQ_FIND,      1'b1, 0,    0,   0));
        issue(pack_req(REQ_FIND,      1'b0, 0,    0,   0));
        issue(pack_req(REQ_WRITE_BIT, 1'b1, 1023, 0,   0));
        issue(pack_req(REQ_FIND,      1'b1, 0,    0,   0));
        issue(pack_req(REQ_WRITE_BIT, 1'b1, 0,    0,   0));
        issue(pack_req(REQ_FIND,      1'b1, 0,    0,   0));
        issue(pack_req(REQ_LOAD,      1'b0, 0,    0,   8'h00));
        issue(pack_req(REQ_LOAD,      1'b0, 0,    5,   8'hA5));
        issue(pack_req(REQ_READ,      1'b0, 0,    5,   0));
        issue(pack_req(REQ_FILL,      1'b1, 0,    0,   0));
        issue(pack_req(REQ_FIND,      1'b0, 0,    0,   0));
        issue(pack_req(REQ_WRITE_BIT, 1'b0, 513,  0,   0));
        issue(pack_req(REQ_FIND,      1'b0, 0,    0,   0));
        issue(pack_req(REQ_CODE_UNUSED, 1'b1, 1023, 127, 8'hFF));
        issue(pack_req(REQ_CODE_LAST,   1'b0, 0,    0,   0));
        // small map: fill stays inside, indexes past the end are refused
        set_span(8'd4);
        issue(pack_req(REQ_FILL,      1'b0, 0,    0,   0));
        issue(pack_req(REQ_WRITE_BIT, 1'b1, 32,   0,   0));
        issue(pack_req(REQ_WRITE_BIT, 1'b1, 31,   0,   0));
        issue(pack_req(REQ_LOAD,      1'b0, 0,    4,   8'h5A));
        issue(pack_req(REQ_READ,      1'b0, 0,    4,   0));
        issue(pack_req(REQ_FIND,      1'b1, 0,    0,   0));
        set_span(8'd0);
        issue(pack_req(REQ_FIND,      1'b0, 0,    0,   0));
        issue(pack_req(REQ_WRITE_BIT, 1'b1, 0,    0,   0));
        issue(pack_req(REQ_FILL,      1'b1, 0,    0,   0));
        // oversized setting is clamped to the whole map
        set_span(SPAN_MAX);
        issue(pack_req(REQ_READ,      1'b0, 0,    4,   0));
    endtask

    task automatic run_random(input logic [7:0] span, input int unsigned count);
        int unsigned live;
        int unsigned burst_left;
        live       = (int'(span) > MAP_BYTES) ? MAP_BYTES : int'(span);
        burst_left = $urandom_range(1, 16);
        for (int k = 0; k < count; k++)
        begin
            issue(random_request(live));
            if ($urandom_range(0, 59) == 0)
            begin
                drain();
            end
            else if (burst_left == 0)
            begin
                pause($urandom_range(1, 12));
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
                                                         : $urandom_range(1, 16);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        cycles            = 0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        fill_polarity     = 1'b0;
        sink_mode         = SINK_OPEN;
        mode_left         = 0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = '0;
        req_ch.bit_value  = 1'b0;
        req_ch.bit_index  = '0;
        req_ch.byte_index = '0;
        req_ch.byte_data  = '0;
        rsp_ch.ready      = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int s = 0; s < SPAN_STEPS; s++)
        begin
            set_span(SPAN_PLAN[s]);
            run_random(SPAN_PLAN[s], ITEMS_PER_SPAN);
        end
        set_span(8'($urandom_range(1, MAP_BYTES)));
        run_random(8'(MAP_BYTES), ITEMS_PER_SPAN);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0 && due_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
